@@ src/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: operation codes,
// field widths, the cell command, the result lane and the controller states.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int KIND_W       = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_READ   = 3'd2,
        KIND_SEARCH = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic shift_in;
        logic shift_out;
        logic load;
        logic search;
    } t_cell_op;

    typedef struct packed {
        logic              tag;
        logic [DATA_W-1:0] data;
    } t_lane;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         fpos;
    } t_res;

endpackage

@@ src/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an element, shifts it toward its neighbors on insert
// and delete, and drives one stage of the result lane toward slot zero.
// ----------------------------------------------------------------------------
module ple_cell
    import ple_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int INDEX    = 0,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic              i_clk,
    input  t_cell_op          i_op,
    input  logic [IDX_W-1:0]  i_slot,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left_data,
    input  logic [DATA_W-1:0] i_right_data,
    input  t_lane             i_right_lane,
    output logic [DATA_W-1:0] o_data,
    output t_lane             o_lane
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

    logic [DATA_W-1:0] r_data;
    t_lane             r_lane;
    logic              w_sel;

    assign w_sel = i_op.search ? ((r_data == i_value) && (MY_CNT < i_count))
                               : (MY_IDX == i_slot);

    always_ff @(posedge i_clk) begin
        if (i_op.shift_in) begin
            if (MY_IDX == i_slot) begin
                r_data <= i_value;
            end else if (MY_IDX > i_slot) begin
                r_data <= i_left_data;
            end
        end else if (i_op.shift_out) begin
            if (MY_IDX >= i_slot) begin
                r_data <= i_right_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.load) begin
            r_lane.tag  <= w_sel;
            r_lane.data <= r_data;
        end else begin
            r_lane <= i_right_lane;
        end
    end

    assign o_data = r_data;
    assign o_lane = r_lane;

endmodule

@@ src/ple_ctrl.sv @@
// ----------------------------------------------------------------------------
// ple_ctrl
// Operation sequencer: checks positions, keeps the element count, drives the
// cell row, watches the result lane at slot zero and holds the output beat.
// ----------------------------------------------------------------------------
module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [POS_W-1:0]         i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_status,
    output logic signed [DATA_W-1:0] o_value_out,
    output logic [POS_W-1:0]         o_found_position,
    output logic [POS_W-1:0]         o_length,
    output logic                     o_is_empty,
    output t_cell_op                 o_op,
    output logic [IDX_W-1:0]         o_slot,
    output logic [CNT_W-1:0]         o_count,
    input  t_lane                    i_lane
);

    localparam int WIDE_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_lim,   n_lim;
    logic [IDX_W-1:0] r_idx,   n_idx;
    t_kind            r_kind,  n_kind;
    t_res             r_res,   n_res;
    logic             r_out_valid, n_out_valid;
    t_res             r_out,   n_out;
    logic [POS_W-1:0] r_len,   n_len;
    logic             r_empty, n_empty;

    logic              w_accept;
    logic [WIDE_W-1:0] w_pos;
    logic [WIDE_W-1:0] w_cnt;
    logic              w_ins_ok;
    logic              w_acc_ok;
    logic              w_out_free;
    t_cell_op          w_op;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_pos      = WIDE_W'(i_position);
    assign w_cnt      = WIDE_W'(r_count);
    assign w_ins_ok   = (i_position != '0) && (w_pos <= w_cnt + WIDE_W'(1))
                        && (r_count != CNT_W'(CAPACITY));
    assign w_acc_ok   = (i_position != '0) && (w_pos <= w_cnt);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lim       = r_lim;
        n_idx       = r_idx;
        n_kind      = r_kind;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_len       = r_len;
        n_empty     = r_empty;
        w_op        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res   = '{status: 1'b1, value: '0, fpos: '0};
                    n_kind  = t_kind'(i_kind);
                    n_lim   = r_count;
                    n_idx   = '0;
                    n_state = S_EMIT;
                    unique case (t_kind'(i_kind))
                        KIND_INSERT: begin
                            if (w_ins_ok) begin
                                w_op.shift_in = 1'b1;
                                n_count       = r_count + CNT_W'(1);
                                n_res.status  = 1'b0;
                            end
                        end
                        KIND_DELETE: begin
                            if (w_acc_ok) begin
                                w_op.shift_out = 1'b1;
                                w_op.load      = 1'b1;
                                n_count        = r_count - CNT_W'(1);
                                n_state        = S_SCAN;
                            end
                        end
                        KIND_READ: begin
                            if (w_acc_ok) begin
                                w_op.load = 1'b1;
                                n_state   = S_SCAN;
                            end
                        end
                        KIND_SEARCH: begin
                            n_res.status = 1'b0;
                            if (r_count != '0) begin
                                w_op.load   = 1'b1;
                                w_op.search = 1'b1;
                                n_state     = S_SCAN;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count      = '0;
                            n_res.status = 1'b0;
                        end
                        default: begin
                            n_res.status = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_lane.tag) begin
                    n_res.status = 1'b0;
                    if (r_kind == KIND_SEARCH) begin
                        n_res.fpos = POS_W'(r_idx) + POS_W'(1);
                    end else begin
                        n_res.value = i_lane.data;
                    end
                    n_state = S_EMIT;
                end else if (CNT_W'(r_idx) + CNT_W'(1) == r_lim) begin
                    n_res   = '{status: 1'b0, value: '0, fpos: '0};
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_len       = POS_W'(r_count);
                    n_empty     = (r_count == '0);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim   <= n_lim;
        r_idx   <= n_idx;
        r_kind  <= n_kind;
        r_res   <= n_res;
        r_out   <= n_out;
        r_len   <= n_len;
        r_empty <= n_empty;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_value_out      = r_out.value;
    assign o_found_position = r_out.fpos;
    assign o_length         = r_len;
    assign o_is_empty       = r_empty;
    assign o_op             = w_op;
    assign o_slot           = IDX_W'(w_pos - WIDE_W'(1));
    assign o_count          = r_count;

endmodule

@@ src/positional_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of up to CAPACITY signed 32-bit values, edited and queried by
// 1-based position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// One operation is taken at a time. Insert, clear, an empty-list search and
// any rejected operation go from accept to the emit state, then the result
// register; an insert shifts the cells from its position up on accept. Read,
// delete and other searches first copy the elements into a result lane that
// moves one slot per cycle toward slot zero, where the sequencer watches it
// to the tagged slot or the list's end. The result register frees the input
// side, so the next operation can start while a result waits to be taken.
// The list is empty after reset; no clearing pass is needed.
module positional_list_engine_unit
    import ple_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_status,
    output logic signed [DATA_W-1:0] o_value_out,
    output logic [POS_W-1:0]         o_found_position,
    output logic [POS_W-1:0]         o_length,
    output logic                     o_is_empty
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_cell_op          w_op;
    logic [IDX_W-1:0]  w_slot;
    logic [CNT_W-1:0]  w_count;
    logic [DATA_W-1:0] w_data [CAPACITY+1];
    t_lane             w_lane [CAPACITY+1];

    assign w_data[CAPACITY] = '0;
    assign w_lane[CAPACITY] = '0;

    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_value_out      (o_value_out),
        .o_found_position (o_found_position),
        .o_length         (o_length),
        .o_is_empty       (o_is_empty),
        .o_op             (w_op),
        .o_slot           (w_slot),
        .o_count          (w_count),
        .i_lane           (w_lane[0])
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_rest
            assign w_left = w_data[g-1];
        end

        ple_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_slot       (w_slot),
            .i_count      (w_count),
            .i_value      (i_value),
            .i_left_data  (w_left),
            .i_right_data (w_data[g+1]),
            .i_right_lane (w_lane[g+1]),
            .o_data       (w_data[g]),
            .o_lane       (w_lane[g])
        );
    end

endmodule

@@ src/ple_checker.sv @@
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker
    import ple_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic                     o_status,
    input logic signed [DATA_W-1:0] o_value_out,
    input logic [POS_W-1:0]         o_found_position,
    input logic [POS_W-1:0]         o_length,
    input logic                     o_is_empty
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_value_out) && $stable(o_found_position)
            && $stable(o_length))
        else $error("stalled result beat changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_length == '0)))
        else $error("empty flag disagrees with length");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> (o_value_out == '0) && (o_found_position == '0))
        else $error("error result carries data");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_value_out      (o_value_out),
    .o_found_position (o_found_position),
    .o_length         (o_length),
    .o_is_empty       (o_is_empty)
);

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list engine. A shadow copy of the
// list predicts the answer to every accepted operation, and each returned beat
// is compared field by field in order. Directed corner cases are followed by
// random grow, shrink and mixed phases, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ple_pkg::*;

    localparam int CAP          = DEF_CAPACITY;
    localparam int RANDOM_OPS   = 1800;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = CAP + 20;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
    } t_list_op;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         fpos;
        logic [POS_W-1:0]         len;
        logic                     empty;
    } t_list_answer;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [KIND_W-1:0]        in_kind = '0;
    logic [POS_W-1:0]         in_position = '0;
    logic signed [DATA_W-1:0] in_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     out_status;
    logic signed [DATA_W-1:0] out_value;
    logic [POS_W-1:0]         out_fpos;
    logic [POS_W-1:0]         out_length;
    logic                     out_empty;

    t_list_op                 pending_ops[$];
    t_list_answer             list_answers[$];
    logic signed [DATA_W-1:0] shadow_list[CAP];
    logic signed [DATA_W-1:0] value_pool[16];
    int                       shadow_len = 0;
    int                       gen_len = 0;
    int                       mismatches = 0;
    int                       ops_done = 0;
    int                       peak_len = 0;
    int                       full_rejects = 0;
    int                       search_hits = 0;
    int                       in_gap = 0;
    int                       out_gap = 0;
    bit                       in_idle_on = 1'b1;
    bit                       out_idle_on = 1'b1;
    bit                       drv_free;
    t_list_op                 beat_op;
    t_list_answer             want;

    positional_list_engine_unit #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (in_kind),
        .i_position      (in_position),
        .i_value         (in_value),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (out_status),
        .o_value_out     (out_value),
        .o_found_position(out_fpos),
        .o_length        (out_length),
        .o_is_empty      (out_empty)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_list_answer apply_list_op(input t_list_op op);
        t_list_answer ans;
        int           p;
        bit           hit;
        ans = '0;
        p   = op.pos;
        hit = 1'b0;
        case (op.kind)
            KIND_INSERT: begin
                if (p < 1 || p > shadow_len + 1 || shadow_len >= CAP) begin
                    ans.status = 1'b1;
                    if (shadow_len >= CAP) full_rejects++;
                end else begin
                    for (int i = shadow_len; i > p - 1; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[p-1] = op.val;
                    shadow_len++;
                end
            end
            KIND_DELETE: begin
                if (p < 1 || p > shadow_len) begin
                    ans.status = 1'b1;
                end else begin
                    ans.value = shadow_list[p-1];
                    for (int i = p - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            KIND_READ: begin
                if (p < 1 || p > shadow_len) ans.status = 1'b1;
                else ans.value = shadow_list[p-1];
            end
            KIND_SEARCH: begin
                for (int i = 0; i < shadow_len; i++) begin
                    if (!hit && shadow_list[i] == op.val) begin
                        hit      = 1'b1;
                        ans.fpos = POS_W'(i + 1);
                    end
                end
                if (hit) search_hits++;
            end
            KIND_CLEAR: shadow_len = 0;
            default: ans.status = 1'b1;
        endcase
        ans.len   = POS_W'(shadow_len);
        ans.empty = (shadow_len == 0);
        if (shadow_len > peak_len) peak_len = shadow_len;
        ops_done++;
        return ans;
    endfunction

    task automatic push_op(input logic [KIND_W-1:0] kind, input int pos,
                           input logic signed [DATA_W-1:0] val);
        pending_ops.push_back('{kind: kind, pos: pos[POS_W-1:0], val: val});
        case (kind)
            KIND_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAP) gen_len++;
            KIND_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
            KIND_CLEAR:  gen_len = 0;
            default: ;
        endcase
    endtask

    task automatic check_field(input string field, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t ns: %s expected %0h actual %0h", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            drv_free = !in_valid;
            if (in_valid && in_ready) begin
                beat_op = '{kind: in_kind, pos: in_position, val: in_value};
                list_answers.push_back(apply_list_op(beat_op));
                drv_free = 1'b1;
                if ($urandom_range(0, 39) == 0) in_idle_on = !in_idle_on;
            end
            if (drv_free) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_ops.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (in_idle_on && pending_ops.size() > QUIET_TAIL &&
                             $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(1, 19) - 1;
                    in_valid <= 1'b0;
                end else begin
                    beat_op = pending_ops.pop_front();
                    in_valid    <= 1'b1;
                    in_kind     <= beat_op.kind;
                    in_position <= beat_op.pos;
                    in_value    <= beat_op.val;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (list_answers.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result beat with nothing expected, status %0h value %0h",
                             $time, out_status, out_value);
                end else begin
                    want = list_answers.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(out_status));
                    check_field("value_out", want.value, out_value);
                    check_field("found_position", DATA_W'(want.fpos), DATA_W'(out_fpos));
                    check_field("length", DATA_W'(want.len), DATA_W'(out_length));
                    check_field("is_empty", DATA_W'(want.empty), DATA_W'(out_empty));
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else if (out_idle_on && pending_ops.size() > QUIET_TAIL &&
                         $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
            if ($urandom_range(0, 49) == 0) out_idle_on = !out_idle_on;
        end
    end

    initial begin
        int                       seg_left;
        int                       ins_w;
        int                       del_w;
        int                       clr_w;
        int                       r;
        int                       pick;
        int                       hi;
        int                       p;
        logic [KIND_W-1:0]        k;
        logic signed [DATA_W-1:0] v;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 10; i++) value_pool[i] = $urandom_range(0, 40) - 20;
        for (int i = 10; i < 16; i++) value_pool[i] = $urandom;

        push_op(KIND_READ, 1, 0);
        push_op(KIND_DELETE, 1, 0);
        push_op(KIND_SEARCH, 0, 0);
        push_op(KIND_INSERT, 0, 5);
        push_op(KIND_INSERT, 2, 5);
        push_op(KIND_INSERT, 1, 32'h7FFF_FFFF);
        push_op(KIND_INSERT, 2, 32'h8000_0000);
        push_op(KIND_INSERT, 1, -1);
        push_op(KIND_INSERT, 4, 0);
        push_op(KIND_INSERT, 2, -1);
        push_op(KIND_READ, 1, 0);
        push_op(KIND_READ, 5, 0);
        push_op(KIND_READ, 6, 0);
        push_op(KIND_SEARCH, 0, 32'h8000_0000);
        push_op(KIND_SEARCH, 127, -1);
        push_op(KIND_SEARCH, 0, 77);
        push_op(KIND_DELETE, 5, 0);
        push_op(KIND_DELETE, 1, 0);
        push_op(KIND_DELETE, 0, 0);
        push_op(KIND_INSERT, 127, 9);
        push_op(KIND_CLEAR + 3'd1, 127, -1);
        push_op(KIND_CLEAR + 3'd2, 0, 0);
        push_op(KIND_CLEAR + 3'd3, 127, 32'h5555_AAAA);
        push_op(KIND_READ, 127, 0);
        push_op(KIND_CLEAR, 0, 0);
        push_op(KIND_SEARCH, 0, -1);

        seg_left = 0;
        ins_w    = 0;
        del_w    = 0;
        clr_w    = 0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(120, 250);
                case ((n == 0) ? 0 : $urandom_range(0, 2))
                    0: begin ins_w = 55; del_w = 10; clr_w = 0; end
                    1: begin ins_w = 10; del_w = 55; clr_w = 1; end
                    default: begin ins_w = 30; del_w = 30; clr_w = 2; end
                endcase
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (r < ins_w) k = KIND_INSERT;
            else if (r < ins_w + del_w) k = KIND_DELETE;
            else if (r < ins_w + del_w + 15) k = KIND_READ;
            else if (r < ins_w + del_w + 30) k = KIND_SEARCH;
            else if (r < ins_w + del_w + 30 + clr_w) k = KIND_CLEAR;
            else if (r < ins_w + del_w + 32 + clr_w) k = KIND_CLEAR + 3'($urandom_range(1, 3));
            else k = KIND_READ;

            hi   = (k == KIND_INSERT) ? gen_len + 1 : gen_len;
            pick = $urandom_range(0, 99);
            if (pick < 12 || hi < 1) p = $urandom_range(0, 127);
            else if (pick < 20) p = hi;
            else if (pick < 26) p = 1;
            else p = $urandom_range(1, hi);

            if ($urandom_range(0, 9) < 7) v = value_pool[$urandom_range(0, 15)];
            else v = $urandom;
            push_op(k, p, v);
        end

        while (pending_ops.size() > 0 || in_valid || list_answers.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (list_answers.size() > 0) begin
            mismatches++;
            $display("%0t ns: %0d expected results never arrived", $time, list_answers.size());
        end
        $display("Checked %0d list operations; length peaked at %0d of %0d.",
                 ops_done, peak_len, CAP);
        $display("Saw %0d full-list insert rejections and %0d search hits.",
                 full_rejects, search_hits);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
